// File: rtl/core/dct_pkg.sv
// Package: widths, coefficient table and shared types for the 8x8 DCT/IDCT unit.
`default_nettype none
package dct_pkg;
  localparam int unsigned BLOCK_SIZE = 8;
  localparam int unsigned ElemW = 12;
  localparam int unsigned StoreW = 20;
  localparam int unsigned CoefW = 16;
  localparam int unsigned RowShift = 11;
  localparam int unsigned ColShift = 19;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_COL,
    ST_OUT
  } state_t;

  // alpha(k)*cos(pi*(2n+1)*k/16) in Q1.15
  function automatic logic signed [CoefW-1:0] coef(input logic [2:0] k, input logic [2:0] n);
    logic [4:0] m;
    logic neg;
    logic signed [CoefW-1:0] mag;
    m = 5'(({2'b00, k} * {1'b0, n, 1'b1}));
    neg = 1'b0;
    mag = '0;
    if (k == 3'd0) begin
      mag = 16'sd11585;
    end else begin
      if (m[4]) begin
        neg = 1'b1;
        m = {1'b0, m[3:0]};
      end
      if (m > 5'd8) begin
        m = 5'd16 - m;
        neg = ~neg;
      end
      case (m[3:0])
        4'd1: mag = 16'sd16069;
        4'd2: mag = 16'sd15137;
        4'd3: mag = 16'sd13623;
        4'd4: mag = 16'sd11585;
        4'd5: mag = 16'sd9102;
        4'd6: mag = 16'sd6270;
        4'd7: mag = 16'sd3196;
        default: mag = 16'sd0;
      endcase
    end
    return neg ? -mag : mag;
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/dct_lane.sv
// One lane: one output element of a 1-D transform, rounded and saturated.
`default_nettype none
module dct_lane #(
  parameter int unsigned IN_W = 20,
  parameter int unsigned SHIFT = 11,
  parameter int unsigned OUT_W = 20,
  parameter logic [2:0] LANE = 3'd0
) (
  input wire logic clk,
  input wire logic en,
  input wire logic inv,
  input wire logic signed [IN_W-1:0] x [8],
  output logic signed [OUT_W-1:0] y
);
  localparam int unsigned ProdW = IN_W + dct_pkg::CoefW;
  localparam int unsigned SumW = ProdW + 3;
  localparam logic signed [SumW-1:0] Half = SumW'(1) <<< (SHIFT - 1);
  localparam logic signed [SumW-SHIFT-1:0] Hi = (SumW-SHIFT)'((1 <<< (OUT_W-1)) - 1);
  localparam logic signed [SumW-SHIFT-1:0] Lo =
    (OUT_W == dct_pkg::ElemW) ? -Hi : -Hi - 1;

  logic signed [ProdW-1:0] prod [8];
  logic signed [SumW-1:0] sum;
  logic signed [SumW-SHIFT-1:0] q;

  // products registered, then summed, rounded and saturated
  always_ff @(posedge clk) begin
    if (en) begin
      for (int b = 0; b < 8; b++) begin
        prod[b] <= ProdW'(x[b]) * ProdW'(inv ? dct_pkg::coef(3'(b), LANE)
                                             : dct_pkg::coef(LANE, 3'(b)));
      end
    end
  end

  always_comb begin
    sum = Half;
    for (int b = 0; b < 8; b++) sum = sum + SumW'(prod[b]);
    q = sum[SumW-1:SHIFT];
    if (q > Hi) y = OUT_W'(Hi);
    else if (q < Lo) y = OUT_W'(Lo);
    else y = OUT_W'(q);
  end
endmodule
`default_nettype wire

// File: rtl/core/dct_idct_8x8_2d_unit.sv
// Top level: 8x8 separable DCT/IDCT with lanes, transpose store and output register.
`default_nettype none
// An item is one row of eight 12-bit samples. Products are registered in the
// accept cycle, then summed, rounded and stored in the next, and no row is
// taken in that cycle, so a new row is not taken until the last one is
// stored. After the eighth row a second set of eight lanes runs over one
// stored column at a time: the products are registered, then summed, rounded
// and loaded into the output register, where the result waits until taken;
// last_column is set on column 7 and no row is taken during the column pass.
// inverse_mode selects forward (0) or inverse (1) transform.
module dct_idct_8x8_2d_unit (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic cfg_wdata,
  input wire logic s_tvalid,
  output logic s_tready,
  input wire logic [95:0] s_tdata,  // elem_0..elem_7, 12 bits each
  output logic m_tvalid,
  input wire logic m_tready,
  output logic [95:0] m_tdata,      // res_0..res_7, 12 bits each
  output logic m_tlast              // last_column
);
  localparam int unsigned BLOCK_SIZE = dct_pkg::BLOCK_SIZE;
  localparam int unsigned IdxW = $clog2(BLOCK_SIZE);
  localparam int unsigned EW = dct_pkg::ElemW;
  localparam int unsigned SW = dct_pkg::StoreW;

  logic inverse_mode;
  dct_pkg::state_t state, state_next;
  logic [IdxW-1:0] row, col;
  logic phase;
  logic signed [SW-1:0] lane_in [8];
  logic signed [SW-1:0] row_y [8];
  logic signed [EW-1:0] col_y [8];
  logic signed [SW-1:0] rin [8];
  logic signed [SW-1:0] cin [8];
  logic accept;

  assign accept = s_tvalid && s_tready;
  assign s_tready = (state == dct_pkg::ST_LOAD) && !phase;

  // lane inputs: input row, or a stored column
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rin[i] = SW'($signed(s_tdata[i*EW +: EW]));
      lane_in[i] = (state == dct_pkg::ST_LOAD) ? rin[i] : cin[i];
    end
  end

  // transpose store: one bank per stored row, read at the current column
  for (genvar r = 0; r < BLOCK_SIZE; r++) begin : g_bank
    logic signed [SW-1:0] mem [BLOCK_SIZE];
    always_ff @(posedge clk) begin
      if (state == dct_pkg::ST_LOAD && phase && row == IdxW'(r)) begin
        for (int i = 0; i < BLOCK_SIZE; i++) mem[i] <= row_y[i];
      end
    end
    assign cin[r] = mem[col];
  end

  for (genvar g = 0; g < 8; g++) begin : g_lane
    dct_lane #(.IN_W(SW), .SHIFT(dct_pkg::RowShift), .OUT_W(SW), .LANE(3'(g))) u_row (
      .clk(clk), .en(accept), .inv(inverse_mode), .x(lane_in), .y(row_y[g])
    );
    dct_lane #(.IN_W(SW), .SHIFT(dct_pkg::ColShift), .OUT_W(EW), .LANE(3'(g))) u_col (
      .clk(clk), .en(state == dct_pkg::ST_COL && !phase), .inv(inverse_mode),
      .x(lane_in), .y(col_y[g])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dct_pkg::ST_LOAD: if (phase && row == IdxW'(BLOCK_SIZE-1)) state_next = dct_pkg::ST_COL;
      dct_pkg::ST_COL: if (phase) state_next = dct_pkg::ST_OUT;
      dct_pkg::ST_OUT: if (m_tready) begin
        state_next = (col == IdxW'(BLOCK_SIZE-1)) ? dct_pkg::ST_LOAD : dct_pkg::ST_COL;
      end
      default: state_next = dct_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dct_pkg::ST_LOAD;
      inverse_mode <= 1'b0;
      row <= '0;
      col <= '0;
      phase <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) inverse_mode <= cfg_wdata;
      case (state)
        dct_pkg::ST_LOAD: begin
          if (accept) phase <= 1'b1;
          if (phase) begin
            phase <= 1'b0;
            row <= row + 1'b1;
          end
        end
        dct_pkg::ST_COL: begin
          phase <= ~phase;
          if (phase) m_tvalid <= 1'b1;
        end
        dct_pkg::ST_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            col <= col + 1'b1;
          end
        end
        default: phase <= 1'b0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == dct_pkg::ST_COL && phase) begin
      for (int i = 0; i < 8; i++) m_tdata[i*EW +: EW] <= col_y[i];
      m_tlast <= (col == IdxW'(BLOCK_SIZE-1));
    end
  end
endmodule
`default_nettype wire
